FILE: src/thp_pkg.sv
// Shared types, constants and arithmetic helpers of the sensor compensation core.
`timescale 1ns / 1ps
package thp_pkg;

  // Configuration register indexes
  localparam logic [2:0] CfgTemp   = 3'd0;
  localparam logic [2:0] CfgPressA = 3'd1;
  localparam logic [2:0] CfgPressB = 3'd2;
  localparam logic [2:0] CfgPressC = 3'd3;
  localparam logic [2:0] CfgHum    = 3'd4;

  localparam int unsigned DivWidth = 64;

  localparam logic signed [31:0] TempMinCenti = -32'sd4000;
  localparam logic signed [31:0] TempMaxCenti = 32'sd8500;
  localparam logic [31:0] PressMin     = 32'd3000000;
  localparam logic [31:0] PressMax     = 32'd11000000;
  localparam logic [31:0] HumInterMax  = 32'd419430400;
  localparam logic [31:0] FineOffsetP  = 32'd128000;
  localparam logic [31:0] FineOffsetH  = 32'd76800;
  localparam logic [63:0] PressBias47  = 64'd140737488355328;
  localparam logic [63:0] PressFull    = 64'd1048576;
  localparam logic [63:0] PressScale   = 64'd3125;

  typedef struct packed {
    logic [14:0] temp;
    logic [6:0]  hum;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic [14:0] temp;
    logic [23:0] press;
    logic [6:0]  hum;
  } res_t;

  // Partial products of a 64-bit product kept modulo 2^64
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] x;
  } mp_t;

  function automatic mp_t mp_make(logic [63:0] a, logic [63:0] b);
    mp_t m;
    m.lo = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    m.x  = a[31:0] * b[63:32] + a[63:32] * b[31:0];
    return m;
  endfunction

  function automatic logic [63:0] mp_sum(mp_t m);
    return m.lo + {m.x, 32'd0};
  endfunction

  function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
    logic [31:0] p;
    p = a * b;
    return p;
  endfunction

  // Signed divide by 2^k, truncating toward zero
  function automatic logic [31:0] sdiv32(logic [31:0] a, int unsigned k);
    logic [31:0] bias;
    logic [31:0] s;
    bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    s = a + bias;
    return 32'($signed(s) >>> k);
  endfunction

  function automatic logic [63:0] sdiv64(logic [63:0] a, int unsigned k);
    logic [63:0] bias;
    logic [63:0] s;
    bias = a[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
    s = a + bias;
    return 64'($signed(s) >>> k);
  endfunction

  function automatic logic [31:0] sx32(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

FILE: src/thp_div64.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module thp_div64 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  input  thp_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [63:0]         quo_o,
  output thp_pkg::side_t      side_o
);

  localparam int unsigned N = thp_pkg::DivWidth;

  logic                 v_q    [0:N];
  logic [N-1:0]         rem_q  [0:N];
  logic [N-1:0]         dvd_q  [0:N];
  logic [N-1:0]         quo_q  [0:N];
  logic [N-1:0]         dsr_q  [0:N];
  logic                 neg_q  [0:N];
  thp_pkg::side_t       side_q [0:N];

  logic [N-1:0]         dvd_d, dsr_d;
  logic                 neg_d;

  // take magnitudes, remember the quotient sign
  always_comb begin
    dvd_d = num_i[N-1] ? N'(0 - num_i) : num_i;
    dsr_d = den_i[N-1] ? N'(0 - den_i) : den_i;
    neg_d = num_i[N-1] ^ den_i[N-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      dvd_q[0]  <= dvd_d;
      quo_q[0]  <= '0;
      dsr_q[0]  <= dsr_d;
      neg_q[0]  <= neg_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [N:0]   trial;
    logic         ge;
    logic [N-1:0] rem_d;

    assign trial = {rem_q[i], dvd_q[i][N-1]};
    assign ge    = trial >= {1'b0, dsr_q[i]};
    assign rem_d = ge ? N'(trial - {1'b0, dsr_q[i]}) : trial[N-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= rem_d;
        dvd_q[i+1]  <= {dvd_q[i][N-2:0], 1'b0};
        quo_q[i+1]  <= {quo_q[i][N-2:0], ge};
        dsr_q[i+1]  <= dsr_q[i];
        neg_q[i+1]  <= neg_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  logic                 vo_q;
  logic [N-1:0]         qo_q, qo_d;
  thp_pkg::side_t       so_q;

  // restore the sign
  assign qo_d = neg_q[N] ? N'(0 - quo_q[N]) : quo_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qo_q <= qo_d;
      so_q <= side_q[N];
    end
  end

  assign valid_o = vo_q;
  assign quo_o   = qo_q;
  assign side_o  = so_q;

endmodule

FILE: src/thp_sensor_compensation_core.sv
// Top level of the temperature, pressure and humidity compensation pipeline.
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while in_stall_o is low; the 64-bit pressure divide is a 66-stage
//   pipeline (one quotient bit per stage) and sets most of the latency.
// Output: result register plus one skid entry; input stall rises only when the skid is full.
// Reset: rst_ni clears all valid bits, including the skid's, and every calibration register to zero.
module thp_sensor_compensation_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  input  logic [15:0] raw_humidity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [23:0] pressure_centi_pa_o,
  output logic [6:0]  humidity_percent_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [47:0] tcal_q;
  logic [63:0] pcal_a_q, pcal_b_q, hcal_q;
  logic [15:0] pcal_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q   <= '0;
      pcal_a_q <= '0;
      pcal_b_q <= '0;
      pcal_c_q <= '0;
      hcal_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        thp_pkg::CfgTemp:   tcal_q   <= cfg_data_i[47:0];
        thp_pkg::CfgPressA: pcal_a_q <= cfg_data_i;
        thp_pkg::CfgPressB: pcal_b_q <= cfg_data_i;
        thp_pkg::CfgPressC: pcal_c_q <= cfg_data_i[15:0];
        thp_pkg::CfgHum:    hcal_q   <= cfg_data_i;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Unpack coefficients; temperature and humidity in 32 bits, pressure in 64 bits
  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  always_comb begin
    t1 = {16'd0, tcal_q[15:0]};
    t2 = thp_pkg::sx32(tcal_q[31:16]);
    t3 = thp_pkg::sx32(tcal_q[47:32]);
    p1 = {48'd0, pcal_a_q[15:0]};
    p2 = thp_pkg::sx64(pcal_a_q[31:16]);
    p3 = thp_pkg::sx64(pcal_a_q[47:32]);
    p4 = thp_pkg::sx64(pcal_a_q[63:48]);
    p5 = thp_pkg::sx64(pcal_b_q[15:0]);
    p6 = thp_pkg::sx64(pcal_b_q[31:16]);
    p7 = thp_pkg::sx64(pcal_b_q[47:32]);
    p8 = thp_pkg::sx64(pcal_b_q[63:48]);
    p9 = thp_pkg::sx64(pcal_c_q);
    h1 = {24'd0, hcal_q[7:0]};
    h2 = thp_pkg::sx32(hcal_q[23:8]);
    h3 = {24'd0, hcal_q[31:24]};
    h4 = {{20{hcal_q[43]}}, hcal_q[43:32]};
    h5 = {{20{hcal_q[55]}}, hcal_q[55:44]};
    h6 = {{24{hcal_q[63]}}, hcal_q[63:56]};
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid entry is occupied
  // ---------------------------------------------------------------------------
  logic skid_v_q;
  logic en;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // ---------------------------------------------------------------------------
  // Front section, stages 0..18: temperature, humidity, pressure divide operands
  // ---------------------------------------------------------------------------
  logic fv_q [0:18];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= 18; i++) fv_q[i] <= 1'b0;
    end else if (en) begin
      fv_q[0] <= in_valid_i;
      for (int i = 1; i <= 18; i++) fv_q[i] <= fv_q[i-1];
    end
  end

  // delay taps for values that ride along unchanged
  logic [19:0] rp_q   [0:10];
  logic [19:0] rp_d   [1:10];
  logic [15:0] rh_q   [0:6];
  logic [15:0] rh_d   [1:6];
  logic [14:0] temp_q [5:17];
  logic [14:0] temp_d [6:17];
  logic [31:0] hc_q   [12:16];
  logic [31:0] hc_d   [13:16];
  logic [63:0] num_q  [14:18];
  logic [63:0] num_d  [15:18];
  logic [63:0] den_q  [14:18];
  logic [63:0] den_d  [15:18];
  logic [31:0] he_q   [7:11];
  logic [31:0] he_d   [8:11];

  logic [19:0] rt0_q;
  logic [31:0] a0_q, a0_d, b0_q, b0_d;                 // stage 1
  logic [31:0] a1_q, a1_d, bb2_q, bb2_d;               // stage 2
  logic [31:0] a2_q, a2_d, b2_q, b2_d;                 // stage 3
  logic [31:0] fine4_q, fine4_d;                       // stage 4
  logic [14:0] temp5_d;                                // stage 5
  logic [63:0] x1_5_q, x1_5_d;
  logic [31:0] ha5_q, ha5_d;
  thp_pkg::mp_t mxx6_q, mxx6_d, mp5_6_q, mp5_6_d, mp2_6_q, mp2_6_d; // stage 6
  logic [31:0] hd6_q, hd6_d, ah6_6_q, ah6_6_d, ah3_6_q, ah3_6_d;
  logic [63:0] xx7_q, xx7_d, x1p5_7_q, x1p5_7_d, x1p2_7_q, x1p2_7_d; // stage 7
  logic [31:0] he7_d, hb7_q, hb7_d, hc7_q, hc7_d;
  thp_pkg::mp_t mp6_8_q, mp6_8_d, mp3_8_q, mp3_8_d;    // stage 8
  logic [63:0] x1p5_8_q, x1p5_8_d, x1p2_8_q, x1p2_8_d;
  logic [31:0] hm8_q, hm8_d;
  logic [63:0] xxp6_9_q, xxp6_9_d, xxp3_9_q, xxp3_9_d; // stage 9
  logic [63:0] x1p5_9_q, x1p5_9_d, x1p2_9_q, x1p2_9_d;
  logic [31:0] hd9_q, hd9_d;
  logic [63:0] x2_10_q, x2_10_d, v10_q, v10_d;         // stage 10
  logic [31:0] hm10_q, hm10_d;
  logic [63:0] w11_q, w11_d, x4a11_q, x4a11_d;         // stage 11
  logic [31:0] hb11_q, hb11_d;
  thp_pkg::mp_t mw12_q, mw12_d, my12_q, my12_d;        // stage 12
  logic [31:0] hc12_d;
  logic [63:0] wp1_13_q, wp1_13_d, y13_q, y13_d;       // stage 13
  logic [31:0] hq13_q, hq13_d;
  logic [63:0] den14_d, num14_d;                       // stage 14
  logic [31:0] hqq14_q, hqq14_d;
  logic [31:0] hd15_q, hd15_d;                         // stage 15
  logic [31:0] hdh16_q, hdh16_d;                       // stage 16
  logic [31:0] he17_q, he17_d;                         // stage 17
  thp_pkg::side_t side18_q, side18_d;                  // stage 18

  logic [31:0] t_round, t_scaled, h_raw, h_sum, e2;
  logic [63:0] p_rem;

  always_comb begin
    for (int i = 1; i <= 10; i++) rp_d[i] = rp_q[i-1];
    for (int i = 1; i <= 6; i++)  rh_d[i] = rh_q[i-1];
    for (int i = 6; i <= 17; i++) temp_d[i] = temp_q[i-1];
    for (int i = 13; i <= 16; i++) hc_d[i] = hc_q[i-1];
    for (int i = 15; i <= 18; i++) begin
      num_d[i] = num_q[i-1];
      den_d[i] = den_q[i-1];
    end
    for (int i = 8; i <= 11; i++) he_d[i] = he_q[i-1];

    // fine temperature
    a0_d  = {15'd0, rt0_q[19:3]} - {t1[30:0], 1'b0};
    b0_d  = {16'd0, rt0_q[19:4]} - t1;
    a1_d  = thp_pkg::mul32(a0_q, t2);
    bb2_d = thp_pkg::mul32(b0_q, b0_q);
    a2_d  = thp_pkg::sdiv32(a1_q, 11);
    b2_d  = thp_pkg::mul32(thp_pkg::sdiv32(bb2_q, 12), t3);
    fine4_d = a2_q + thp_pkg::sdiv32(b2_q, 14);

    // temperature output, pressure and humidity offsets
    t_round  = {fine4_q[29:0], 2'b00} + fine4_q + 32'd128;
    t_scaled = thp_pkg::sdiv32(t_round, 8);
    if ($signed(t_scaled) < thp_pkg::TempMinCenti) begin
      temp5_d = thp_pkg::TempMinCenti[14:0];
    end else if ($signed(t_scaled) > thp_pkg::TempMaxCenti) begin
      temp5_d = thp_pkg::TempMaxCenti[14:0];
    end else begin
      temp5_d = t_scaled[14:0];
    end
    x1_5_d = {{32{fine4_q[31]}}, fine4_q} - {32'd0, thp_pkg::FineOffsetP};
    ha5_d  = fine4_q - thp_pkg::FineOffsetH;

    // pressure: x1 squared and linear terms
    mxx6_d  = thp_pkg::mp_make(x1_5_q, x1_5_q);
    mp5_6_d = thp_pkg::mp_make(x1_5_q, p5);
    mp2_6_d = thp_pkg::mp_make(x1_5_q, p2);
    xx7_d    = thp_pkg::mp_sum(mxx6_q);
    x1p5_7_d = thp_pkg::mp_sum(mp5_6_q);
    x1p2_7_d = thp_pkg::mp_sum(mp2_6_q);
    mp6_8_d  = thp_pkg::mp_make(xx7_q, p6);
    mp3_8_d  = thp_pkg::mp_make(xx7_q, p3);
    x1p5_8_d = x1p5_7_q;
    x1p2_8_d = x1p2_7_q;
    xxp6_9_d = thp_pkg::mp_sum(mp6_8_q);
    xxp3_9_d = thp_pkg::mp_sum(mp3_8_q);
    x1p5_9_d = x1p5_8_q;
    x1p2_9_d = x1p2_8_q;
    x2_10_d  = xxp6_9_q + (x1p5_9_q << 17) + (p4 << 35);
    v10_d    = thp_pkg::sdiv64(xxp3_9_q, 8) + (x1p2_9_q << 12);
    w11_d    = thp_pkg::PressBias47 + v10_q;
    p_rem    = thp_pkg::PressFull - {44'd0, rp_q[10]};
    x4a11_d  = (p_rem << 31) - x2_10_q;
    mw12_d   = thp_pkg::mp_make(w11_q, p1);
    my12_d   = thp_pkg::mp_make(x4a11_q, thp_pkg::PressScale);
    wp1_13_d = thp_pkg::mp_sum(mw12_q);
    y13_d    = thp_pkg::mp_sum(my12_q);
    den14_d  = thp_pkg::sdiv64(wp1_13_q, 33);
    num14_d  = y13_q;

    // humidity
    hd6_d   = thp_pkg::mul32(h5, ha5_q);
    ah6_6_d = thp_pkg::mul32(ha5_q, h6);
    ah3_6_d = thp_pkg::mul32(ha5_q, h3);
    h_raw   = {2'b00, rh_q[6], 14'd0};
    h_sum   = h_raw - {h4[11:0], 20'd0} - hd6_q + 32'd16384;
    he7_d   = thp_pkg::sdiv32(h_sum, 15);
    hb7_d   = thp_pkg::sdiv32(ah6_6_q, 10);
    hc7_d   = thp_pkg::sdiv32(ah3_6_q, 11) + 32'd32768;
    hm8_d   = thp_pkg::mul32(hb7_q, hc7_q);
    hd9_d   = thp_pkg::sdiv32(hm8_q, 10) + 32'd2097152;
    hm10_d  = thp_pkg::mul32(hd9_q, h2);
    hb11_d  = thp_pkg::sdiv32(hm10_q + 32'd8192, 14);
    hc12_d  = thp_pkg::mul32(he_q[11], hb11_q);
    hq13_d  = thp_pkg::sdiv32(hc_q[12], 15);
    hqq14_d = thp_pkg::mul32(hq13_q, hq13_q);
    hd15_d  = thp_pkg::sdiv32(hqq14_q, 7);
    hdh16_d = thp_pkg::mul32(hd15_q, h1);
    e2      = hc_q[16] - thp_pkg::sdiv32(hdh16_q, 4);
    if (e2[31]) begin
      he17_d = '0;
    end else if (e2 > thp_pkg::HumInterMax) begin
      he17_d = thp_pkg::HumInterMax;
    end else begin
      he17_d = e2;
    end

    // whole percent: divide by 4096 then 1024; the clamp keeps the result within 100
    side18_d.temp = temp_q[17];
    side18_d.hum  = he17_q[28:22];
    side18_d.zero = (den_q[17] == 64'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt0_q    <= raw_temperature_i;
      rp_q[0]  <= raw_pressure_i;
      rh_q[0]  <= raw_humidity_i;
      for (int i = 1; i <= 10; i++) rp_q[i] <= rp_d[i];
      for (int i = 1; i <= 6; i++)  rh_q[i] <= rh_d[i];
      temp_q[5] <= temp5_d;
      for (int i = 6; i <= 17; i++) temp_q[i] <= temp_d[i];
      hc_q[12] <= hc12_d;
      for (int i = 13; i <= 16; i++) hc_q[i] <= hc_d[i];
      num_q[14] <= num14_d;
      den_q[14] <= den14_d;
      for (int i = 15; i <= 18; i++) begin
        num_q[i] <= num_d[i];
        den_q[i] <= den_d[i];
      end
      he_q[7] <= he7_d;
      for (int i = 8; i <= 11; i++) he_q[i] <= he_d[i];

      a0_q     <= a0_d;
      b0_q     <= b0_d;
      a1_q     <= a1_d;
      bb2_q    <= bb2_d;
      a2_q     <= a2_d;
      b2_q     <= b2_d;
      fine4_q  <= fine4_d;
      x1_5_q   <= x1_5_d;
      ha5_q    <= ha5_d;
      mxx6_q   <= mxx6_d;
      mp5_6_q  <= mp5_6_d;
      mp2_6_q  <= mp2_6_d;
      hd6_q    <= hd6_d;
      ah6_6_q  <= ah6_6_d;
      ah3_6_q  <= ah3_6_d;
      xx7_q    <= xx7_d;
      x1p5_7_q <= x1p5_7_d;
      x1p2_7_q <= x1p2_7_d;
      hb7_q    <= hb7_d;
      hc7_q    <= hc7_d;
      mp6_8_q  <= mp6_8_d;
      mp3_8_q  <= mp3_8_d;
      x1p5_8_q <= x1p5_8_d;
      x1p2_8_q <= x1p2_8_d;
      hm8_q    <= hm8_d;
      xxp6_9_q <= xxp6_9_d;
      xxp3_9_q <= xxp3_9_d;
      x1p5_9_q <= x1p5_9_d;
      x1p2_9_q <= x1p2_9_d;
      hd9_q    <= hd9_d;
      x2_10_q  <= x2_10_d;
      v10_q    <= v10_d;
      hm10_q   <= hm10_d;
      w11_q    <= w11_d;
      x4a11_q  <= x4a11_d;
      hb11_q   <= hb11_d;
      mw12_q   <= mw12_d;
      my12_q   <= my12_d;
      wp1_13_q <= wp1_13_d;
      y13_q    <= y13_d;
      hq13_q   <= hq13_d;
      hqq14_q  <= hqq14_d;
      hd15_q   <= hd15_d;
      hdh16_q  <= hdh16_d;
      he17_q   <= he17_d;
      side18_q <= side18_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pressure divide; temperature, humidity and the zero-divisor flag ride along
  // ---------------------------------------------------------------------------
  logic           dv;
  logic [63:0]    dq;
  thp_pkg::side_t dside;

  thp_div64 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q[18]),
    .num_i   (num_q[18]),
    .den_i   (den_q[18]),
    .side_i  (side18_q),
    .valid_o (dv),
    .quo_o   (dq),
    .side_o  (dside)
  );

  // ---------------------------------------------------------------------------
  // Back section, stages 1..9: pressure correction terms and final scaling
  // ---------------------------------------------------------------------------
  logic pv_q [1:9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= 9; i++) pv_q[i] <= 1'b0;
    end else if (en) begin
      pv_q[1] <= dv;
      for (int i = 2; i <= 9; i++) pv_q[i] <= pv_q[i-1];
    end
  end

  thp_pkg::side_t sd_q [1:9];
  thp_pkg::side_t sd_d [2:9];
  logic [63:0] xq_q [1:5];
  logic [63:0] xq_d [2:5];

  thp_pkg::mp_t m8_1_q, m8_1_d, mqq2_q, mqq2_d, mq9_4_q, mq9_4_d;
  logic [63:0] q1_q, q1_d, p8x4_2_q, p8x4_2_d, qq3_q, qq3_d;
  logic [63:0] x2b3_q, x2b3_d, x2b4_q, x2b4_d, x2b5_q, x2b5_d;
  logic [63:0] qqp9_5_q, qqp9_5_d, s6_q, s6_d, x4c7_q, x4c7_d, m8_q, m8_d;
  logic [23:0] press9_q, press9_d;
  logic [63:0] half, scaled;

  always_comb begin
    for (int i = 2; i <= 9; i++) sd_d[i] = sd_q[i-1];
    for (int i = 2; i <= 5; i++) xq_d[i] = xq_q[i-1];

    q1_d     = thp_pkg::sdiv64(dq, 13);
    m8_1_d   = thp_pkg::mp_make(p8, dq);
    mqq2_d   = thp_pkg::mp_make(q1_q, q1_q);
    p8x4_2_d = thp_pkg::mp_sum(m8_1_q);
    qq3_d    = thp_pkg::mp_sum(mqq2_q);
    x2b3_d   = thp_pkg::sdiv64(p8x4_2_q, 19);
    mq9_4_d  = thp_pkg::mp_make(qq3_q, p9);
    x2b4_d   = x2b3_q;
    qqp9_5_d = thp_pkg::mp_sum(mq9_4_q);
    x2b5_d   = x2b4_q;
    s6_d     = xq_q[5] + thp_pkg::sdiv64(qqp9_5_q, 25) + x2b5_q;
    x4c7_d   = thp_pkg::sdiv64(s6_q, 8) + (p7 << 4);
    // times 100 as 64 + 32 + 4
    half     = thp_pkg::sdiv64(x4c7_q, 1);
    m8_d     = (half << 6) + (half << 5) + (half << 2);
    scaled   = thp_pkg::sdiv64(m8_q, 7);
    if (sd_q[8].zero) begin
      press9_d = thp_pkg::PressMin[23:0];
    end else if (scaled[31:0] < thp_pkg::PressMin) begin
      press9_d = thp_pkg::PressMin[23:0];
    end else if (scaled[31:0] > thp_pkg::PressMax) begin
      press9_d = thp_pkg::PressMax[23:0];
    end else begin
      press9_d = scaled[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[1] <= dside;
      for (int i = 2; i <= 9; i++) sd_q[i] <= sd_d[i];
      xq_q[1] <= dq;
      for (int i = 2; i <= 5; i++) xq_q[i] <= xq_d[i];
      q1_q     <= q1_d;
      m8_1_q   <= m8_1_d;
      mqq2_q   <= mqq2_d;
      p8x4_2_q <= p8x4_2_d;
      qq3_q    <= qq3_d;
      x2b3_q   <= x2b3_d;
      mq9_4_q  <= mq9_4_d;
      x2b4_q   <= x2b4_d;
      qqp9_5_q <= qqp9_5_d;
      x2b5_q   <= x2b5_d;
      s6_q     <= s6_d;
      x4c7_q   <= x4c7_d;
      m8_q     <= m8_d;
      press9_q <= press9_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid entry
  // ---------------------------------------------------------------------------
  thp_pkg::res_t last_res;
  thp_pkg::res_t out_q, out_d, skid_q, skid_d;
  logic          out_v_d, skid_v_d;
  logic          last_v;

  always_comb begin
    last_res.temp  = sd_q[9].temp;
    last_res.press = press9_q;
    last_res.hum   = sd_q[9].hum;
    last_v   = pv_q[9] && en;
    out_d    = out_q;
    out_v_d  = out_valid_o;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!out_valid_o || !out_stall_i) begin
      // output free: drain the skid first, else take the pipeline head
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = last_res;
        out_v_d = last_v;
      end
    end else if (last_v) begin
      // output held: park the pipeline head in the skid
      skid_d   = last_res;
      skid_v_d = 1'b1;
    end
  end

  logic out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o         = out_v_q;
  assign temperature_centi_o = $signed(out_q.temp);
  assign pressure_centi_pa_o = out_q.press;
  assign humidity_percent_o  = out_q.hum;

endmodule
